// ===== src/clhm_pkg.sv =====
// ----------------------------------------------------------------------------
// clhm_pkg: shared definitions for the channel link health monitor
// Widths, register indexes, reset values and the per-channel state record.
// ----------------------------------------------------------------------------
package clhm_pkg;

    localparam int CHANNELS  = 16;
    localparam int TIME_BITS = 40;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths of a transfer
    localparam int CHAN_W  = 4;
    localparam int TIN_W   = 40;
    localparam int SLOT_W  = 2;
    localparam int RATE_W  = 20;
    localparam int HEAD_W  = 48;
    localparam int CNT_W   = 32;
    localparam int MS_W    = 16;

    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SAMPLE_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPEND_STALL_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISALIGN_RECOVER_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INJECT_DELAY_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_STALE_MS  = 3'd4;

    localparam logic [RATE_W-1:0] RST_OUTPUT_SAMPLE_RATE  = 20'd48000;
    localparam logic [MS_W-1:0]   RST_SUSPEND_STALL_MS    = 16'd500;
    localparam logic [MS_W-1:0]   RST_MISALIGN_RECOVER_MS = 16'd1000;
    localparam logic [MS_W-1:0]   RST_INJECT_DELAY_MS     = 16'd200;
    localparam logic [MS_W-1:0]   RST_HEARTBEAT_STALE_MS  = 16'd1000;

    // Operation codes and slot states
    localparam logic OP_EVALUATE = 1'b0;
    localparam logic OP_RESET    = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_NONE   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_ACTIVE = 2'd2;

    typedef logic [TIME_BITS-1:0] time_val_t;

    typedef struct packed {
        logic [HEAD_W-1:0] last_head_pos;
        time_val_t         head_change_time;
        logic              starving_seen;
        logic [CNT_W-1:0]  last_starve_count;
        logic              episode_active;
        logic [CNT_W-1:0]  stall_episodes;
        time_val_t         misaligned_since;
        logic [CNT_W-1:0]  last_gap_seen;
        logic [CNT_W-1:0]  gap_baseline;
        logic [CNT_W-1:0]  episode_baseline;
        logic              online_before;
        time_val_t         online_since;
    } chan_state_t;

    // Declared from the top bit down, so channel_out sits in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0]  recent_faults;
        logic              misaligned;
        logic              suspended;
        logic              inject;
        logic              online;
        logic [CHAN_W-1:0] channel_out;
    } result_t;

endpackage

// ===== src/channel_link_health_monitor.sv =====
// ----------------------------------------------------------------------------
// channel_link_health_monitor: per-channel audio ring health monitor
// An input transfer is held in the input register and its result in the
// result register behind m_tvalid. One item per cycle while m_tready allows;
// channel state is read, updated and written back between those registers.
// Reset (aresetn low, synchronous) clears all channel state to zero, loads the
// register defaults and empties both pipeline registers.
// ----------------------------------------------------------------------------
module channel_link_health_monitor
    import clhm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // channel, now, slot state, heartbeat time, slot sample rate, ring bound,
    // write position, starve count, gap total, muted, transport playing, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // channel_out, online, inject, suspended, misaligned, recent_faults
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [RATE_W-1:0] out_rate_reg;
    logic [MS_W-1:0]   stall_ms_reg;
    logic [MS_W-1:0]   recover_ms_reg;
    logic [MS_W-1:0]   inject_ms_reg;
    logic [MS_W-1:0]   stale_ms_reg;

    // Pipeline registers
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 in_op_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              result_next;

    chan_state_t state_reg [CHANNELS];
    chan_state_t st_cur;
    chan_state_t st_next;

    logic advance;
    logic process;
    logic ch_ok;
    logic [CH_IDX_W-1:0] ch_idx;

    // Unpacked fields of the held item
    logic [CHAN_W-1:0] f_channel;
    time_val_t         f_now;
    logic [SLOT_W-1:0] f_slot;
    time_val_t         f_hb;
    logic [RATE_W-1:0] f_rate;
    logic              f_bound;
    logic [HEAD_W-1:0] f_head;
    logic [CNT_W-1:0]  f_starve;
    logic [CNT_W-1:0]  f_gaps;
    logic              f_muted;
    logic              f_playing;

    assign f_channel = in_data_reg[3:0];
    assign f_now     = TIME_BITS'(in_data_reg[43:4]);
    assign f_slot    = in_data_reg[45:44];
    assign f_hb      = TIME_BITS'(in_data_reg[85:46]);
    assign f_rate    = in_data_reg[105:86];
    assign f_bound   = in_data_reg[106];
    assign f_head    = in_data_reg[154:107];
    assign f_starve  = in_data_reg[186:155];
    assign f_gaps    = in_data_reg[218:187];
    assign f_muted   = in_data_reg[219];
    assign f_playing = in_data_reg[220];

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign ch_ok  = 32'(f_channel) < 32'(CHANNELS);
    assign ch_idx = CH_IDX_W'(f_channel);
    assign st_cur = state_reg[ch_idx];

    always_comb begin
        logic present, active, fresh, rate_ok, fb, moved, susp, adv;
        logic starving, new_episode, gap_changed, mis, online, inj;
        time_val_t dt_head, dt_mis, dt_online;
        logic [CNT_W-1:0] gaps, stalls;
        logic [CNT_W:0]   sum;

        susp        = 1'b0;
        adv         = 1'b0;
        starving    = 1'b0;
        new_episode = 1'b0;
        gap_changed = 1'b0;
        mis         = 1'b0;
        online      = 1'b0;
        inj         = 1'b0;
        dt_mis      = '0;
        dt_online   = '0;
        gaps        = '0;
        stalls      = '0;
        sum         = '0;

        present = f_slot != SLOT_NONE;
        active  = f_slot == SLOT_ACTIVE;
        fresh   = present && ((f_now - f_hb) < TIME_BITS'(stale_ms_reg));
        rate_ok = present && (f_rate == out_rate_reg);
        fb      = fresh && f_bound;
        moved   = f_head != st_cur.last_head_pos;
        dt_head = f_now - st_cur.head_change_time;

        st_next = st_cur;
        result_next = '0;
        result_next.channel_out = f_channel;

        if (in_op_reg == OP_RESET) begin
            st_next.online_before     = 1'b0;
            st_next.online_since      = '0;
            st_next.misaligned_since  = '0;
            st_next.last_head_pos     = '0;
            st_next.head_change_time  = '0;
            st_next.last_gap_seen     = f_gaps;
            st_next.gap_baseline      = f_gaps;
            st_next.episode_baseline  = st_cur.stall_episodes;
            st_next.last_starve_count = f_starve;
            st_next.episode_active    = 1'b0;
            st_next.starving_seen     = 1'b0;
        end else begin
            // Write-head tracking: a moving head restarts the stall timer.
            susp = fb && !moved && (dt_head >= TIME_BITS'(stall_ms_reg));
            adv  = fb && (moved ? (stall_ms_reg != '0)
                                : (dt_head < TIME_BITS'(stall_ms_reg)));
            if (fb && moved) begin
                st_next.last_head_pos    = f_head;
                st_next.head_change_time = f_now;
            end
            starving = (f_starve != st_cur.last_starve_count) ||
                       (!(fb && moved) && st_cur.starving_seen);
            st_next.starving_seen     = starving;
            st_next.last_starve_count = f_starve;

            // One episode per suspension with starved reads while playing.
            new_episode = susp && f_playing && starving && !st_cur.episode_active;
            if (!susp || !f_playing) begin
                st_next.episode_active = 1'b0;
            end else if (starving) begin
                st_next.episode_active = 1'b1;
            end
            st_next.stall_episodes = st_cur.stall_episodes + CNT_W'(new_episode);

            gap_changed = f_gaps != st_cur.last_gap_seen;
            dt_mis = f_now - st_cur.misaligned_since;
            if (st_next.episode_active || gap_changed) begin
                st_next.misaligned_since = f_now;
                mis = recover_ms_reg != '0;
            end else begin
                mis = dt_mis < TIME_BITS'(recover_ms_reg);
            end
            st_next.last_gap_seen = f_gaps;

            if (!mis && active && fb && rate_ok && !susp && adv) begin
                st_next.gap_baseline     = f_gaps;
                st_next.episode_baseline = st_next.stall_episodes;
            end

            online = active && fb && rate_ok && !mis && !susp;
            dt_online = f_now - st_cur.online_since;
            inj = 1'b0;
            if (online) begin
                if (!st_cur.online_before) begin
                    st_next.online_since = f_now;
                    inj = f_muted || (inject_ms_reg == '0);
                end else begin
                    inj = f_muted || (dt_online >= TIME_BITS'(inject_ms_reg));
                end
            end
            st_next.online_before = online;

            gaps   = (f_gaps > st_next.gap_baseline) ? f_gaps - st_next.gap_baseline : '0;
            stalls = (st_next.stall_episodes > st_next.episode_baseline)
                   ? st_next.stall_episodes - st_next.episode_baseline : '0;
            sum    = {1'b0, gaps} + {1'b0, stalls};

            result_next.online        = online;
            result_next.inject        = inj;
            result_next.suspended     = susp;
            result_next.misaligned    = mis;
            result_next.recent_faults = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        end

        // A channel beyond the table leaves state alone and reports only itself.
        if (!ch_ok) begin
            result_next = '0;
            result_next.channel_out = f_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_rate_reg   <= RST_OUTPUT_SAMPLE_RATE;
            stall_ms_reg   <= RST_SUSPEND_STALL_MS;
            recover_ms_reg <= RST_MISALIGN_RECOVER_MS;
            inject_ms_reg  <= RST_INJECT_DELAY_MS;
            stale_ms_reg   <= RST_HEARTBEAT_STALE_MS;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end

            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_OUTPUT_SAMPLE_RATE:  out_rate_reg   <= cfg_wdata;
                    REG_SUSPEND_STALL_MS:    stall_ms_reg   <= cfg_wdata[MS_W-1:0];
                    REG_MISALIGN_RECOVER_MS: recover_ms_reg <= cfg_wdata[MS_W-1:0];
                    REG_INJECT_DELAY_MS:     inject_ms_reg  <= cfg_wdata[MS_W-1:0];
                    REG_HEARTBEAT_STALE_MS:  stale_ms_reg   <= cfg_wdata[MS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
        if (process) begin
            out_reg <= result_next;
        end
    end

    // Channel state table: read, modify and write back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (process && ch_ok) begin
            state_reg[ch_idx] <= st_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_inject_needs_online: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (!out_reg.inject || out_reg.online))
        else $error("inject reported for a channel that is not online");

    a_online_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.online) |-> (!out_reg.suspended && !out_reg.misaligned))
        else $error("online reported while suspended or misaligned");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_valid_reg)
        else $error("processed item produced no result");

    a_reset_op_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && ch_ok && (in_op_reg == OP_RESET)) |=>
            (!state_reg[$past(ch_idx)].episode_active &&
             !state_reg[$past(ch_idx)].online_before))
        else $error("reset operation left episode or online tracking set");

endmodule

// ===== dv/tb_channel_link_health_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_channel_link_health_monitor: self-checking bench for the link monitor
// Sends channel snapshots and tracking resets in bursts against a result side
// that stalls on its own pattern. Every accepted transfer is run through a
// local per-channel health predictor, and each result transfer is compared
// field by field with the oldest expected result. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_channel_link_health_monitor;
    import clhm_pkg::*;

    localparam int RANDOM_PER_PHASE = 140;
    localparam int PHASE_COUNT      = 6;
    localparam int DRAIN_TAIL       = 8;
    localparam int WATCHDOG_LIMIT   = 2000;

    localparam logic [SLOT_W-1:0] SLOT_UNDEFINED = 2'd3;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

    typedef struct {
        logic              op;
        logic [CHAN_W-1:0] channel;
        time_val_t         now_ms;
        logic [SLOT_W-1:0] slot;
        time_val_t         beat_ms;
        logic [RATE_W-1:0] rate;
        logic              bound;
        logic [HEAD_W-1:0] head;
        logic [CNT_W-1:0]  starve;
        logic [CNT_W-1:0]  gaps;
        logic              muted;
        logic              playing;
    } snapshot_t;

    typedef struct {
        snapshot_t item;
        bit        typed;
        result_t   want;
    } table_row_t;

    typedef struct {
        logic [RATE_W-1:0] rate;
        logic [MS_W-1:0]   stall;
        logic [MS_W-1:0]   recover;
        logic [MS_W-1:0]   inject;
        logic [MS_W-1:0]   stale;
    } link_cfg_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the registers and of the per-channel tracking.
    logic [RATE_W-1:0] cfg_rate    = RST_OUTPUT_SAMPLE_RATE;
    logic [MS_W-1:0]   cfg_stall   = RST_SUSPEND_STALL_MS;
    logic [MS_W-1:0]   cfg_recover = RST_MISALIGN_RECOVER_MS;
    logic [MS_W-1:0]   cfg_inject  = RST_INJECT_DELAY_MS;
    logic [MS_W-1:0]   cfg_stale   = RST_HEARTBEAT_STALE_MS;
    chan_state_t       chan_track [CHANNELS];

    result_t    expected_results [$];
    table_row_t rows [$];
    int         fail_count = 0;

    // Stimulus side: a running clock and plausible per-channel producer state.
    time_val_t         clock_ms;
    int unsigned       step_max = RST_SUSPEND_STALL_MS / 8 + 2;
    logic [HEAD_W-1:0] track_head   [CHANNELS];
    logic [CNT_W-1:0]  track_starve [CHANNELS];
    logic [CNT_W-1:0]  track_gaps   [CHANNELS];
    int                burst_left = 0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    channel_link_health_monitor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    function automatic time_val_t elapsed(time_val_t later, time_val_t earlier);
        return later - earlier;
    endfunction

    function automatic result_t predict_health(snapshot_t it);
        chan_state_t      st;
        result_t          r;
        logic             present, active, fresh, rate_ok, susp, adv, mis, online;
        logic [CNT_W-1:0] gap_delta, ep_delta;
        logic [CNT_W:0]   fault_sum;
        st = chan_track[it.channel];
        r = '0;
        r.channel_out = it.channel;
        if (it.op == OP_RESET) begin
            st.online_before     = 1'b0;
            st.online_since      = '0;
            st.misaligned_since  = '0;
            st.last_head_pos     = '0;
            st.head_change_time  = '0;
            st.last_gap_seen     = it.gaps;
            st.gap_baseline      = it.gaps;
            st.episode_baseline  = st.stall_episodes;
            st.last_starve_count = it.starve;
            st.episode_active    = 1'b0;
            st.starving_seen     = 1'b0;
            chan_track[it.channel] = st;
            return r;
        end
        present = it.slot != SLOT_NONE;
        active  = it.slot == SLOT_ACTIVE;
        fresh   = present && (elapsed(it.now_ms, it.beat_ms) < cfg_stale);
        rate_ok = present && (it.rate == cfg_rate);
        susp    = 1'b0;
        adv     = 1'b0;
        if (fresh && it.bound) begin
            if (it.head != st.last_head_pos) begin
                st.last_head_pos    = it.head;
                st.head_change_time = it.now_ms;
                st.starving_seen    = 1'b0;
            end else if (elapsed(it.now_ms, st.head_change_time) >= cfg_stall) begin
                susp = 1'b1;
            end
            adv = elapsed(it.now_ms, st.head_change_time) < cfg_stall;
        end
        if (it.starve != st.last_starve_count) begin
            st.starving_seen = 1'b1;
        end
        st.last_starve_count = it.starve;
        // An episode is counted once, on the first starved suspension while playing.
        if (!susp || !it.playing) begin
            st.episode_active = 1'b0;
        end else if (st.starving_seen) begin
            if (!st.episode_active) begin
                st.stall_episodes = st.stall_episodes + 1'b1;
            end
            st.episode_active = 1'b1;
        end
        if (st.episode_active) begin
            st.misaligned_since = it.now_ms;
        end
        if (it.gaps != st.last_gap_seen) begin
            st.misaligned_since = it.now_ms;
            st.last_gap_seen    = it.gaps;
        end
        mis = elapsed(it.now_ms, st.misaligned_since) < cfg_recover;
        if (!mis && active && fresh && rate_ok && it.bound && !susp && adv) begin
            st.gap_baseline     = it.gaps;
            st.episode_baseline = st.stall_episodes;
        end
        online = active && fresh && rate_ok && it.bound && !mis && !susp;
        if (online) begin
            if (!st.online_before) begin
                st.online_since = it.now_ms;
            end
            st.online_before = 1'b1;
            r.inject = it.muted || (elapsed(it.now_ms, st.online_since) >= cfg_inject);
        end else begin
            st.online_before = 1'b0;
        end
        r.online     = online;
        r.suspended  = susp;
        r.misaligned = mis;
        gap_delta = (it.gaps > st.gap_baseline) ? it.gaps - st.gap_baseline : '0;
        ep_delta  = (st.stall_episodes > st.episode_baseline)
                    ? st.stall_episodes - st.episode_baseline : '0;
        fault_sum = gap_delta + ep_delta;
        r.recent_faults = fault_sum[CNT_W] ? '1 : fault_sum[CNT_W-1:0];
        chan_track[it.channel] = st;
        return r;
    endfunction

    function automatic snapshot_t snap(logic op, logic [CHAN_W-1:0] ch, time_val_t now,
                                       logic [SLOT_W-1:0] slot, time_val_t hb,
                                       logic [RATE_W-1:0] rate, logic bound,
                                       logic [HEAD_W-1:0] head, logic [CNT_W-1:0] starve,
                                       logic [CNT_W-1:0] gaps, logic muted, logic playing);
        snapshot_t it;
        it.op      = op;
        it.channel = ch;
        it.now_ms  = now;
        it.slot    = slot;
        it.beat_ms = hb;
        it.rate    = rate;
        it.bound   = bound;
        it.head    = head;
        it.starve  = starve;
        it.gaps    = gaps;
        it.muted   = muted;
        it.playing = playing;
        return it;
    endfunction

    function automatic result_t zero_result(logic [CHAN_W-1:0] ch);
        result_t r;
        r = '0;
        r.channel_out = ch;
        return r;
    endfunction

    function automatic void add_row(snapshot_t it, bit typed, result_t want);
        table_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        rows.insert(rows.size(), row);
    endfunction

    task automatic send_snapshot(snapshot_t it, bit typed, result_t want);
        result_t predicted;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        // Three pad bits fill the transfer up to whole bytes.
        s_tdata  <= {3'b000, it.playing, it.muted, it.gaps, it.starve, it.head, it.bound,
                     it.rate, it.beat_ms, it.slot, it.now_ms, it.channel};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = predict_health(it);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_OUTPUT_SAMPLE_RATE:  cfg_rate    = val[RATE_W-1:0];
            REG_SUSPEND_STALL_MS:    cfg_stall   = val[MS_W-1:0];
            REG_MISALIGN_RECOVER_MS: cfg_recover = val[MS_W-1:0];
            REG_INJECT_DELAY_MS:     cfg_inject  = val[MS_W-1:0];
            REG_HEARTBEAT_STALE_MS:  cfg_stale   = val[MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(link_cfg_t c);
        write_reg(REG_OUTPUT_SAMPLE_RATE, c.rate);
        write_reg(REG_SUSPEND_STALL_MS, CFG_DATA_W'(c.stall));
        write_reg(REG_MISALIGN_RECOVER_MS, CFG_DATA_W'(c.recover));
        write_reg(REG_INJECT_DELAY_MS, CFG_DATA_W'(c.inject));
        write_reg(REG_HEARTBEAT_STALE_MS, CFG_DATA_W'(c.stale));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        // Scale the clock steps to the stall time so suspensions come and go.
        step_max = c.stall / 8 + 2;
    endtask

    task automatic make_random_snapshot(output snapshot_t it);
        int unsigned ch;
        int unsigned roll;
        if ($urandom_range(0, 99) < 8) begin
            // Noise: every field free across its full width.
            it.op      = 1'($urandom_range(0, 1));
            it.channel = CHAN_W'($urandom);
            it.now_ms  = time_val_t'({$urandom, $urandom});
            it.slot    = SLOT_W'($urandom_range(0, 3));
            it.beat_ms = time_val_t'({$urandom, $urandom});
            it.rate    = RATE_W'($urandom);
            it.bound   = 1'($urandom_range(0, 1));
            it.head    = HEAD_W'({$urandom, $urandom});
            it.starve  = $urandom;
            it.gaps    = $urandom;
            it.muted   = 1'($urandom_range(0, 1));
            it.playing = 1'($urandom_range(0, 1));
        end else begin
            ch = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                             : $urandom_range(0, CHANNELS - 1);
            clock_ms = clock_ms + $urandom_range(0, step_max);
            it.op      = ($urandom_range(0, 99) < 4) ? OP_RESET : OP_EVALUATE;
            it.channel = CHAN_W'(ch);
            it.now_ms  = clock_ms;
            it.slot    = ($urandom_range(0, 99) < 85) ? SLOT_ACTIVE
                                                      : SLOT_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
                it.beat_ms = clock_ms - time_val_t'({$urandom, $urandom});
            end else begin
                it.beat_ms = clock_ms - $urandom_range(0, cfg_stale + cfg_stale / 4 + 1);
            end
            it.rate  = ($urandom_range(0, 99) < 88) ? cfg_rate : RATE_W'($urandom);
            it.bound = $urandom_range(0, 99) < 92;
            if ($urandom_range(0, 1) == 0) begin
                track_head[ch] = ($urandom_range(0, 19) == 0)
                                 ? HEAD_W'({$urandom, $urandom})
                                 : track_head[ch] + $urandom_range(1, 4096);
            end
            it.head = track_head[ch];
            if ($urandom_range(0, 99) < 25) begin
                track_starve[ch] = track_starve[ch] + $urandom_range(1, 3);
            end
            it.starve = track_starve[ch];
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                track_gaps[ch] = track_gaps[ch] + $urandom_range(1, 3);
            end else if (roll == 6) begin
                track_gaps[ch] = $urandom;
            end
            it.gaps    = track_gaps[ch];
            it.muted   = $urandom_range(0, 99) < 20;
            it.playing = $urandom_range(0, 99) < 80;
        end
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("field %s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: m_tdata %0h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("channel_out", CNT_W'(want.channel_out), CNT_W'(m_tdata[3:0]));
                check_field("online", CNT_W'(want.online), CNT_W'(m_tdata[4]));
                check_field("inject", CNT_W'(want.inject), CNT_W'(m_tdata[5]));
                check_field("suspended", CNT_W'(want.suspended), CNT_W'(m_tdata[6]));
                check_field("misaligned", CNT_W'(want.misaligned), CNT_W'(m_tdata[7]));
                check_field("recent_faults", want.recent_faults, m_tdata[39:8]);
            end
        end
    end

    // The result side stalls on its own pattern, picking a new random mode when each run ends.
    rx_mode_e rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_count = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 60);
        end else begin
            rx_left--;
        end
        rx_count++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_count % 4) == 0;
            default:   m_tready <= 1'b0;
        endcase
    end

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        link_cfg_t  phase_cfg [PHASE_COUNT];
        snapshot_t  item;
        result_t    gap_flood;

        foreach (chan_track[i]) begin
            chan_track[i]   = '0;
            track_head[i]   = '0;
            track_starve[i] = '0;
            track_gaps[i]   = '0;
        end
        clock_ms = '0;

        gap_flood = zero_result(4'd2);
        gap_flood.misaligned    = 1'b1;
        gap_flood.recent_faults = '1;

        // Opening rows run with the register defaults on freshly cleared channels.
        add_row(snap(OP_RESET, 4'd0, 40'd0, SLOT_NONE, 40'd0, 20'd0, 1'b0,
                     48'd0, 32'd3, 32'd5, 1'b0, 1'b0), 1'b1, zero_result(4'd0));
        add_row(snap(OP_EVALUATE, 4'd1, 40'd5000, SLOT_NONE, 40'd0, 20'd0, 1'b0,
                     48'd0, 32'd0, 32'd0, 1'b0, 1'b0), 1'b1, zero_result(4'd1));
        add_row(snap(OP_EVALUATE, 4'd2, 40'd5000, SLOT_NONE, 40'd0, 20'd0, 1'b0,
                     48'd0, 32'd0, '1, 1'b0, 1'b0), 1'b1, gap_flood);
        // A healthy channel goes online, injects, stalls, starves and recovers.
        add_row(snap(OP_EVALUATE, 4'd3, 40'd10000, SLOT_ACTIVE, 40'd9990, 20'd48000,
                     1'b1, 48'd100, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd10250, SLOT_ACTIVE, 40'd10240, 20'd48000,
                     1'b1, 48'd200, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd10800, SLOT_ACTIVE, 40'd10790, 20'd48000,
                     1'b1, 48'd200, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd10900, SLOT_ACTIVE, 40'd10890, 20'd48000,
                     1'b1, 48'd200, 32'd1, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd11000, SLOT_ACTIVE, 40'd10990, 20'd48000,
                     1'b1, 48'd200, 32'd1, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd11100, SLOT_ACTIVE, 40'd11090, 20'd48000,
                     1'b1, 48'd300, 32'd1, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd12200, SLOT_ACTIVE, 40'd12190, 20'd48000,
                     1'b1, 48'd400, 32'd1, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd3, 40'd12210, SLOT_ACTIVE, 40'd12200, 20'd48000,
                     1'b1, 48'd500, 32'd1, 32'd0, 1'b1, 1'b1), 1'b0, '0);
        // Slot in the unused state three, then a stale heartbeat.
        add_row(snap(OP_EVALUATE, 4'd4, 40'd15000, SLOT_UNDEFINED, 40'd14990,
                     20'd48000, 1'b1, 48'd7, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd4, 40'd20000, SLOT_ACTIVE, 40'd0, 20'd48000,
                     1'b1, 48'd8, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        // Rate mismatch at the field maximum, then an unbound ring.
        add_row(snap(OP_EVALUATE, 4'd5, 40'd30000, SLOT_ACTIVE, 40'd29999, '1, 1'b1,
                     '1, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd5, 40'd30100, SLOT_ACTIVE, 40'd30099, 20'd48000,
                     1'b0, '1, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        // The clock wraps through zero while the write head stays still.
        add_row(snap(OP_EVALUATE, 4'd6, '1, SLOT_ACTIVE, 40'hFF_FFFF_FF00, 20'd48000,
                     1'b1, 48'd1, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd6, 40'd300, SLOT_ACTIVE, '1, 20'd48000, 1'b1,
                     48'd1, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd6, 40'd700, SLOT_ACTIVE, 40'd600, 20'd48000,
                     1'b1, 48'd1, 32'd0, 32'd0, 1'b0, 1'b1), 1'b0, '0);
        // Tracking resets at the counter extremes.
        add_row(snap(OP_RESET, 4'd3, 40'd40000, SLOT_ACTIVE, 40'd40000, 20'd48000,
                     1'b1, 48'd500, '1, '1, 1'b0, 1'b1), 1'b1, zero_result(4'd3));
        add_row(snap(OP_EVALUATE, 4'd3, 40'd50000, SLOT_ACTIVE, 40'd49999, 20'd48000,
                     1'b1, '1, '1, '1, 1'b1, 1'b0), 1'b0, '0);
        add_row(snap(OP_EVALUATE, 4'd15, '1, SLOT_UNDEFINED, '1, '1, 1'b1, '1, '1,
                     '1, 1'b1, 1'b1), 1'b0, '0);
        add_row(snap(OP_RESET, 4'd15, '1, SLOT_UNDEFINED, '1, '1, 1'b1, '1, '1, '1,
                     1'b1, 1'b1), 1'b1, zero_result(4'd15));
        add_row(snap(OP_EVALUATE, 4'd15, 40'd0, SLOT_NONE, 40'd0, 20'd0, 1'b0,
                     48'd0, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0, '0);

        // Phase zero keeps the reset defaults; the others write every register.
        phase_cfg[0] = '{RST_OUTPUT_SAMPLE_RATE, RST_SUSPEND_STALL_MS, RST_MISALIGN_RECOVER_MS,
                         RST_INJECT_DELAY_MS, RST_HEARTBEAT_STALE_MS};
        phase_cfg[1] = '{20'd48000, 16'd500, 16'd1000, 16'd200, 16'd1000};
        phase_cfg[2] = '{20'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_cfg[3] = '{20'd1000000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[4] = '{RATE_W'($urandom_range(8000, 192000)), MS_W'($urandom_range(1, 3000)),
                         MS_W'($urandom_range(1, 3000)), MS_W'($urandom_range(1, 3000)),
                         MS_W'($urandom_range(1, 3000))};
        phase_cfg[5] = '{20'd44100, 16'd300, 16'd50, 16'd0, 16'hFFFF};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            send_snapshot(rows[i].item, rows[i].typed, rows[i].want);
            pace_sender();
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                wait_drained();
                apply_config(phase_cfg[p]);
            end
            // One phase starts just below the wrap point of the millisecond clock.
            clock_ms = (p == 1) ? time_val_t'('1) - $urandom_range(0, 3000)
                                : time_val_t'({$urandom, $urandom});
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2) begin
                    wait_drained();
                end
                make_random_snapshot(item);
                send_snapshot(item, 1'b0, '0);
                pace_sender();
            end
        end

        wait_drained();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
